### src/cv5_pkg.sv
// shared types, constants and helpers for the 5x5 convolution block
package cv5_pkg;

    localparam int KSIZE          = 5;
    localparam int KTAPS          = KSIZE * KSIZE;
    localparam int DEF_MAX_WIDTH  = 32;
    localparam int DEF_MAX_HEIGHT = 32;

    localparam logic CMD_WEIGHT = 1'b0;
    localparam logic CMD_PIXEL  = 1'b1;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [5:0] DIM_RESET = 6'd16;

    typedef logic signed [24:0] prod_t;
    typedef logic signed [27:0] rsum_t;
    typedef logic signed [29:0] tsum_t;

    typedef struct packed {
        logic [4:0] row;
        logic [4:0] col;
        logic       last_of_run;
        logic       frame_end;
    } cv5_meta_t;

    typedef struct packed {
        prod_t [KTAPS-1:0] prod;
        cv5_meta_t         meta;
    } cv5_prod_t;

    typedef struct packed {
        rsum_t [KSIZE-1:0] rsum;
        cv5_meta_t         meta;
    } cv5_rsum_t;

    typedef struct packed {
        logic               command;
        logic [4:0]         weight_index;
        logic signed [15:0] weight_value;
        logic [7:0]         pixel_value;
        logic               row_end;
        logic               last_row;
    } cv5_item_t;

    function automatic logic [5:0] clamp_dim(logic [5:0] v, int maxv);
        logic [5:0] x;
        x = v;
        if (x == 6'd0)
        begin
            x = 6'd1;
        end
        if (32'(x) > maxv)
        begin
            x = 6'(maxv);
        end
        return x;
    endfunction

endpackage

### src/cv5_if.sv
// stream channel interfaces for pixels/weights in and features out
interface cv5_pix_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [4:0]         weight_index;
    logic signed [15:0] weight_value;
    logic [7:0]         pixel_value;

    modport source (output valid, command, weight_index, weight_value, pixel_value,
                    input ready);
    modport sink   (input valid, command, weight_index, weight_value, pixel_value,
                    output ready);
endinterface

interface cv5_feat_if;
    logic        valid;
    logic        ready;
    logic [27:0] feature_value;
    logic [4:0]  out_row;
    logic [4:0]  out_col;
    logic        last_of_run;
    logic        frame_end;

    modport source (output valid, feature_value, out_row, out_col, last_of_run, frame_end,
                    input ready);
    modport sink   (input valid, feature_value, out_row, out_col, last_of_run, frame_end,
                    output ready);
endinterface

### src/cv5_line_mem.sv
// line buffer memory: one word per column, four row bytes per word
module cv5_line_mem import cv5_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [1:0]               wr_slot,
    input  logic [7:0]               wr_data,
    output logic [3:0][7:0]          rd_data
);

    logic [3:0][7:0] mem [DEPTH];
    logic [3:0][7:0] rd_data_reg;

    // read returns the word as it was before this edge's byte write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr][wr_slot] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/cv5_engine.sv
// window, kernel weights, output sequencer and product stage
module cv5_engine import cv5_pkg::*;
#(
    parameter int RW = $clog2(DEF_MAX_HEIGHT),
    parameter int CW = $clog2(DEF_MAX_WIDTH)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s1_valid,
    input  cv5_item_t       s1_item,
    input  logic [RW-1:0]   s1_pr,
    input  logic [CW-1:0]   s1_pc,
    input  logic [3:0][7:0] line_data,
    output logic            s1_take,
    output logic            t3_valid,
    output cv5_prod_t       t3,
    input  logic            t3_take
);

    logic [4:0][4:0][7:0] win_reg;
    logic signed [15:0]   weight_reg [KTAPS];

    logic          job_v_reg;
    logic [RW-1:0] pr_reg;
    logic [CW-1:0] pc_reg;
    logic [1:0]    dr_reg, dc_reg, dr_end_reg, dc_end_reg, dc_start_reg;
    logic          frame_last_reg;

    logic      t3_v_reg;
    cv5_prod_t t3_reg;

    logic            t3_free, emit, is_last, s2_free;
    logic [4:0][7:0] col_new;
    logic            has_out;
    logic [1:0]      dr_start, dc_start, dr_end, dc_end;
    cv5_prod_t       prod_next;
    logic [RW-1:0]   row_full;
    logic [CW-1:0]   col_full;

    assign t3_free = !t3_v_reg || t3_take;
    assign emit    = job_v_reg && t3_free;
    assign is_last = (dr_reg == dr_end_reg) && (dc_reg == dc_end_reg);
    assign s2_free = !job_v_reg || (emit && is_last);
    assign s1_take = s1_valid && s2_free;

    // new window column: four buffered rows plus the incoming pixel
    always_comb
    begin
        logic [1:0] slot;
        for (int k = 0; k < 4; k++)
        begin
            slot = s1_pr[1:0] + 2'(k);
            col_new[k] = (32'(s1_pr) < 4 - k) ? 8'd0 : line_data[slot];
        end
        col_new[4] = s1_item.pixel_value;
    end

    always_comb
    begin
        has_out  = (s1_item.command == CMD_PIXEL)
                   && (s1_item.last_row || 32'(s1_pr) >= 2)
                   && (s1_item.row_end || 32'(s1_pc) >= 2);
        dr_start = (s1_item.last_row && 32'(s1_pr) < 2) ? s1_pr[1:0] : 2'd2;
        dc_start = (s1_item.row_end && 32'(s1_pc) < 2) ? s1_pc[1:0] : 2'd2;
        dr_end   = s1_item.last_row ? 2'd0 : 2'd2;
        dc_end   = s1_item.row_end ? 2'd0 : 2'd2;
    end

    // 25 products for the output at offset (dr, dc) behind the newest pixel
    always_comb
    begin
        logic [2:0] wr, wc;
        logic [7:0] pix;
        for (int ki = 0; ki < KSIZE; ki++)
        begin
            for (int kj = 0; kj < KSIZE; kj++)
            begin
                wr = 3'(ki + 2) - {1'b0, dr_reg};
                wc = 3'(kj + 2) - {1'b0, dc_reg};
                pix = (wr <= 3'd4 && wc <= 3'd4) ? win_reg[wr][wc] : 8'd0;
                prod_next.prod[ki*KSIZE+kj] = $signed({1'b0, pix})
                                              * weight_reg[ki*KSIZE+kj];
            end
        end
        row_full = pr_reg - RW'(dr_reg);
        col_full = pc_reg - CW'(dc_reg);
        prod_next.meta.row         = 5'(row_full);
        prod_next.meta.col         = 5'(col_full);
        prod_next.meta.last_of_run = is_last;
        prod_next.meta.frame_end   = is_last && frame_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KTAPS; i++)
            begin
                weight_reg[i] <= '0;
            end
        end
        else if (s1_take && s1_item.command == CMD_WEIGHT
                 && 32'(s1_item.weight_index) < KTAPS)
        begin
            weight_reg[s1_item.weight_index] <= s1_item.weight_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && s1_item.command == CMD_PIXEL)
        begin
            for (int i = 0; i < KSIZE; i++)
            begin
                for (int j = 0; j < KSIZE - 1; j++)
                begin
                    win_reg[i][j] <= (s1_pc == '0) ? 8'd0 : win_reg[i][j+1];
                end
                win_reg[i][KSIZE-1] <= col_new[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_v_reg <= 1'b0;
        end
        else if (s1_take)
        begin
            job_v_reg <= has_out;
        end
        else if (emit && is_last)
        begin
            job_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            pr_reg         <= s1_pr;
            pc_reg         <= s1_pc;
            dr_reg         <= dr_start;
            dc_reg         <= dc_start;
            dc_start_reg   <= dc_start;
            dr_end_reg     <= dr_end;
            dc_end_reg     <= dc_end;
            frame_last_reg <= s1_item.row_end && s1_item.last_row;
        end
        else if (emit && !is_last)
        begin
            if (dc_reg == dc_end_reg)
            begin
                dc_reg <= dc_start_reg;
                dr_reg <= dr_reg - 2'd1;
            end
            else
            begin
                dc_reg <= dc_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t3_v_reg <= 1'b0;
        end
        else if (t3_free)
        begin
            t3_v_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            t3_reg <= prod_next;
        end
    end

    assign t3_valid = t3_v_reg;
    assign t3       = t3_reg;

endmodule

### src/cv5_accum.sv
// adder tree, relu and output register
module cv5_accum import cv5_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       t3_valid,
    input  cv5_prod_t  t3,
    output logic       t3_take,
    cv5_feat_if.source feat_out
);

    logic      t4_v_reg;
    cv5_rsum_t t4_reg;
    logic      out_v_reg;
    logic [27:0] value_reg;
    cv5_meta_t   meta_reg;

    logic      t5_free, t4_free;
    cv5_rsum_t t4_next;
    tsum_t     total;

    assign t5_free = !out_v_reg || feat_out.ready;
    assign t4_free = !t4_v_reg || t5_free;
    assign t3_take = t4_free;

    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            t4_next.rsum[i] = '0;
            for (int j = 0; j < KSIZE; j++)
            begin
                t4_next.rsum[i] = t4_next.rsum[i] + rsum_t'(t3.prod[i*KSIZE+j]);
            end
        end
        t4_next.meta = t3.meta;
    end

    always_comb
    begin
        total = '0;
        for (int i = 0; i < KSIZE; i++)
        begin
            total = total + tsum_t'(t4_reg.rsum[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (t4_free)
            begin
                t4_v_reg <= t3_valid;
            end
            if (t5_free)
            begin
                out_v_reg <= t4_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (t4_free && t3_valid)
        begin
            t4_reg <= t4_next;
        end
        if (t5_free && t4_v_reg)
        begin
            value_reg <= (total < 0) ? 28'd0 : total[27:0];
            meta_reg  <= t4_reg.meta;
        end
    end

    assign feat_out.valid         = out_v_reg;
    assign feat_out.feature_value = value_reg;
    assign feat_out.out_row       = meta_reg.row;
    assign feat_out.out_col       = meta_reg.col;
    assign feat_out.last_of_run   = meta_reg.last_of_run;
    assign feat_out.frame_end     = meta_reg.frame_end;

endmodule

### src/conv5x5_same_relu.sv
// 5x5 same-padding convolution with relu, streaming top level
//
// pix_in carries requests: command 0 loads kernel weight weight_index with
// weight_value, command 1 delivers the next pixel of the image in raster order.
// feat_out carries the results; each pixel causes zero to nine of them, in
// raster order, with last_of_run on the final one and frame_end on the last
// result of the image. image_width and image_height sit on the apb port at
// byte addresses 0 and 4; a write also restarts the frame at row 0, col 0.
// A pixel reads and writes the four-row line buffer in its accept cycle and
// then updates the window; each result then passes through the products,
// the row sums, and the total and relu into the output register.
// Throughput is one request per cycle while each pixel causes at most one
// result and feat_out is free; a pixel causing several results holds pix_in
// until its last result, as the single product stage issues one per cycle.
// At reset the weights clear to zero, both dimensions go to 16 and the frame
// restarts; no clearing pass is needed. A stalled feat_out holds its result
// and back-pressure travels up the pipeline until pix_in.ready drops.
module conv5x5_same_relu import cv5_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    cv5_pix_if.sink     pix_in,
    cv5_feat_if.source  feat_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [5:0]    width_reg, height_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    logic          s1_v_reg;
    cv5_item_t     s1_item_reg;
    logic [RW-1:0] s1_pr_reg;
    logic [CW-1:0] s1_pc_reg;

    logic            cfg_wr, cfg_idx;
    logic [CW-1:0]   pc_cur;
    logic [RW-1:0]   pr_cur;
    logic            row_end, last_row;
    logic            in_acc, pix_acc, s1_take;
    logic [3:0][7:0] line_data;
    logic            t3_valid, t3_take;
    cv5_prod_t       t3;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[2];
    assign prdata  = (cfg_idx == REG_IMAGE_HEIGHT) ? {26'd0, height_reg} : {26'd0, width_reg};

    assign pc_cur   = (32'(col_reg) >= 32'(width_reg)) ? '0 : col_reg;
    assign pr_cur   = (32'(row_reg) >= 32'(height_reg)) ? '0 : row_reg;
    assign row_end  = (32'(pc_cur) + 32'd1) >= 32'(width_reg);
    assign last_row = (32'(pr_cur) + 32'd1) >= 32'(height_reg);

    assign pix_in.ready = !s1_v_reg || s1_take;
    assign in_acc       = pix_in.valid && pix_in.ready;
    assign pix_acc      = in_acc && (pix_in.command == CMD_PIXEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= clamp_dim(pwdata[5:0], MAX_WIDTH);
                REG_IMAGE_HEIGHT: height_reg <= clamp_dim(pwdata[5:0], MAX_HEIGHT);
                default: ;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_acc)
        begin
            if (row_end)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : pr_cur + RW'(1);
            end
            else
            begin
                col_reg <= pc_cur + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (pix_in.ready)
        begin
            s1_v_reg <= pix_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_item_reg.command      <= pix_in.command;
            s1_item_reg.weight_index <= pix_in.weight_index;
            s1_item_reg.weight_value <= pix_in.weight_value;
            s1_item_reg.pixel_value  <= pix_in.pixel_value;
            s1_item_reg.row_end      <= row_end;
            s1_item_reg.last_row     <= last_row;
            s1_pr_reg                <= pr_cur;
            s1_pc_reg                <= pc_cur;
        end
    end

    cv5_line_mem #(.DEPTH(MAX_WIDTH)) u_line_mem (
        .clk     (clk),
        .rd_en   (pix_acc),
        .wr_en   (pix_acc),
        .addr    (pc_cur),
        .wr_slot (pr_cur[1:0]),
        .wr_data (pix_in.pixel_value),
        .rd_data (line_data)
    );

    cv5_engine #(.RW(RW), .CW(CW)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_v_reg),
        .s1_item   (s1_item_reg),
        .s1_pr     (s1_pr_reg),
        .s1_pc     (s1_pc_reg),
        .line_data (line_data),
        .s1_take   (s1_take),
        .t3_valid  (t3_valid),
        .t3        (t3),
        .t3_take   (t3_take)
    );

    cv5_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .t3_valid (t3_valid),
        .t3       (t3),
        .t3_take  (t3_take),
        .feat_out (feat_out)
    );

`ifndef ASSERT_OFF
    a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        feat_out.valid && feat_out.frame_end |-> feat_out.last_of_run)
        else $error("frame_end without last_of_run");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (col_reg == '0) && (row_reg == '0))
        else $error("config write did not restart the frame");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_v_reg && !s1_take |=> s1_v_reg && $stable(s1_item_reg))
        else $error("pending request lost while engine busy");
`endif

endmodule
